@@ rtl/pifs_pkg.sv @@
// Package for the pulse-interval frame synchronizer.
// Holds request codes, register indexes, reset values and small mod-3 helpers.
// Has no dependencies.
`timescale 1ns / 1ps

package pifs_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_PULSE   = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_SUSPEND = 2'd2;
  localparam logic [1:0] REQ_RESUME  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PERIOD       = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE    = 2'd1;
  localparam logic [1:0] CFG_RESYNC_LIMIT = 2'd2;

  // reset values
  localparam logic [15:0] PERIOD_RST       = 16'd5555;
  localparam logic [14:0] TOLERANCE_RST    = 15'd555;
  localparam logic [7:0]  RESYNC_LIMIT_RST = 8'd3;
  localparam logic [1:0]  FRAME_RST        = 2'd3;
  localparam logic [31:0] MISSED_RST       = 32'd3;

  // saturation ceiling of the missed-period count
  localparam logic [31:0] MISSED_MAX = 32'hFFFF_FFFF;

  // reduce a small value (0..7) modulo three
  function automatic logic [1:0] mod3_small(input logic [2:0] v);
    logic [1:0] r;
    case (v)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd2;
      3'd6:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // reduce a 32-bit value modulo three by folding, since every power of four is one mod three
  function automatic logic [1:0] mod3_word(input logic [31:0] v);
    logic [16:0] a;
    logic [9:0]  b;
    logic [6:0]  c;
    logic [5:0]  d;
    logic [4:0]  e;
    logic [3:0]  f;
    a = 17'(v[31:16]) + 17'(v[15:0]);
    b = 10'(a[16:8]) + 10'(a[7:0]);
    c = 7'(b[9:4]) + 7'(b[3:0]);
    d = 6'(c[6:2]) + 6'(c[1:0]);
    e = 5'(d[5:2]) + 5'(d[1:0]);
    f = 4'(e[4:2]) + 4'(e[1:0]);
    return mod3_small(3'(f[3:2]) + 3'(f[1:0]));
  endfunction

endpackage

@@ rtl/pifs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the frame synchronizer.
// Divides a W-bit dividend by a 16-bit divisor; depends on nothing else.
`timescale 1ns / 1ps

module pifs_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [15:0]  divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [15:0]  remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     dvd;
  logic [15:0]      dsr;
  logic [15:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic             running;

  logic [16:0] shifted;
  logic [17:0] diff;
  logic        q_bit;
  logic [15:0] rem_next;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted  = {rem, dvd[W-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr};
    q_bit    = ~diff[17];
    rem_next = q_bit ? diff[15:0] : shifted[15:0];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

@@ rtl/pulse_interval_frame_sync.sv @@
// Pulse-interval frame synchronizer: keeps a three-phase color frame index
// locked to timestamped sync pulses. One item is handled at a time. Advance,
// suspend and resume words, and the first pulse after lock loss (resync),
// pass through ST_CALC alone; a locked pulse that lands in the window, as a
// glitch or as noise passes through ST_CALC and ST_CLASS. A pulse that ends
// a long gap runs the restoring divider, one bit per cycle, and passes
// through ST_CALC, ST_CLASS, ST_DIV and ST_LIMIT. The result word sits in
// an output register, so a new word is taken as soon as the previous
// result is taken. Configuration writes are always ready and must be
// issued only while the block is idle.
`timescale 1ns / 1ps

module pulse_interval_frame_sync #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] timestamp,
  // result words
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [1:0]  frame_index,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DIV_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int EXT_W = TIME_BITS + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_CLASS = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_LIMIT = 3'd4;

  // configuration
  logic [15:0] period;
  logic [14:0] tolerance;
  logic [7:0]  resync_limit;

  // block state
  logic [2:0]           state;
  logic [1:0]           frame;
  logic [31:0]          missed_periods;
  logic [TIME_BITS-1:0] anchor_time;
  logic signed [17:0]   phase_error;
  logic                 locked;
  logic                 suspended;

  // per-item registers
  logic [1:0]           req;
  logic [TIME_BITS-1:0] ts;
  logic [TIME_BITS-1:0] interval;

  // divider hookup
  logic             div_start;
  logic [DIV_W-1:0] div_a;
  logic [15:0]      div_b;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [15:0]      div_r;

  // derived values
  logic [15:0]        per;
  logic [15:0]        lo;
  logic [16:0]        hi;
  logic [EXT_W-1:0]   interval_ext;
  logic               in_window;
  logic               is_glitch;
  logic               is_gap;
  logic [1:0]         win_inc;
  logic [1:0]         resync_frame;
  logic signed [17:0] pe_win;
  logic signed [18:0] glitch_sum;
  logic [18:0]        abs_sum;
  logic [18:0]        abs_pe;
  logic [DIV_W:0]     gap_sum;
  logic [31:0]        gap_missed;
  logic               item_take;
  logic               out_take;

  assign cfg_ready  = 1'b1;
  assign item_take  = item_valid && !item_stall;
  assign out_take   = frame_valid && !frame_stall;
  assign item_stall = (state != ST_IDLE) || (frame_valid && frame_stall);

  // window bounds and interval classification
  always_comb begin
    per          = (period == 16'd0) ? 16'd1 : period;
    lo           = (per > 16'(tolerance)) ? (per - 16'(tolerance)) : 16'd0;
    hi           = 17'(per) + 17'(tolerance);
    interval_ext = EXT_W'(interval);
    in_window    = (interval_ext >= EXT_W'(lo)) && (interval_ext <= EXT_W'(hi));
    is_glitch    = interval_ext < EXT_W'(tolerance);
    is_gap       = interval_ext > EXT_W'(hi);
    win_inc      = (missed_periods == 32'd1) ? 2'd2 : 2'd1;
    resync_frame = pifs_pkg::mod3_small(3'(frame) +
                                        3'(pifs_pkg::mod3_word(missed_periods)));
    pe_win       = $signed(18'(interval_ext) - 18'(per));
    glitch_sum   = 19'(phase_error) + $signed({1'b0, 18'(interval_ext)});
    abs_sum      = glitch_sum[18] ? 19'(-glitch_sum) : 19'(glitch_sum);
    abs_pe       = phase_error[17] ? 19'(-19'(phase_error)) : 19'(phase_error);
    gap_sum      = (DIV_W+1)'(missed_periods) + (DIV_W+1)'(div_q);
    gap_missed   = (gap_sum > (DIV_W+1)'(pifs_pkg::MISSED_MAX)) ?
                   pifs_pkg::MISSED_MAX : gap_sum[31:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period       <= pifs_pkg::PERIOD_RST;
      tolerance    <= pifs_pkg::TOLERANCE_RST;
      resync_limit <= pifs_pkg::RESYNC_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pifs_pkg::CFG_PERIOD:       period       <= cfg_data[15:0];
        pifs_pkg::CFG_TOLERANCE:    tolerance    <= cfg_data[14:0];
        pifs_pkg::CFG_RESYNC_LIMIT: resync_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (item_take) begin
      req <= req_type;
      ts  <= TIME_BITS'(timestamp);
    end
    if (state == ST_CALC) begin
      interval <= ts - anchor_time;
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      frame          <= pifs_pkg::FRAME_RST;
      missed_periods <= pifs_pkg::MISSED_RST;
      anchor_time    <= '0;
      phase_error    <= '0;
      locked         <= 1'b0;
      suspended      <= 1'b0;
      frame_valid    <= 1'b0;
      div_start      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_take) begin
        frame_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_take) begin
            state <= ST_CALC;
          end
        end

        ST_CALC: begin
          state <= ST_IDLE;
          case (req)
            pifs_pkg::REQ_ADVANCE: begin
              frame <= pifs_pkg::mod3_small(3'(frame) + 3'd1);
              if (!suspended) begin
                frame_valid <= 1'b1;
                frame_index <= pifs_pkg::mod3_small(3'(frame) + 3'd1);
              end
            end
            pifs_pkg::REQ_SUSPEND: suspended <= 1'b1;
            pifs_pkg::REQ_RESUME:  suspended <= 1'b0;
            default: begin
              if (!locked) begin
                // resync: fold the missed count in modulo three
                anchor_time    <= ts;
                frame          <= resync_frame;
                missed_periods <= '0;
                phase_error    <= 18'(per);
                locked         <= 1'b1;
                if (!suspended) begin
                  frame_valid <= 1'b1;
                  frame_index <= resync_frame;
                end
              end else begin
                state <= ST_CLASS;
              end
            end
          endcase
        end

        ST_CLASS: begin
          state <= ST_IDLE;
          if (in_window) begin
            frame          <= pifs_pkg::mod3_small(3'(frame) + 3'(win_inc));
            phase_error    <= pe_win;
            anchor_time    <= ts;
            missed_periods <= '0;
            if (!suspended) begin
              frame_valid <= 1'b1;
              frame_index <= pifs_pkg::mod3_small(3'(frame) + 3'(win_inc));
            end
          end else if (is_glitch) begin
            if (abs_sum < abs_pe) begin
              phase_error <= glitch_sum[17:0];
              anchor_time <= ts;
            end
          end else if (is_gap) begin
            div_a     <= DIV_W'(interval);
            div_b     <= per;
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            missed_periods <= gap_missed;
            anchor_time    <= ts - TIME_BITS'(div_r);
            state          <= ST_LIMIT;
          end
        end

        ST_LIMIT: begin
          // drop lock once the missed count passes the limit
          state <= ST_IDLE;
          if (missed_periods > 32'(resync_limit)) begin
            locked <= 1'b0;
            if (missed_periods != pifs_pkg::MISSED_MAX) begin
              missed_periods <= missed_periods + 32'd1;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // shared divider for missed-period count and phase remainder
  pifs_div #(
    .W(DIV_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

endmodule
